@@ sv/cdna_pkg.sv @@
// Shared types and constants for the dynamic node-ID allocator.
`timescale 1ns / 1ps
package cdna_pkg;

	localparam int TableEntriesDefault = 16;
	localparam int UidBytesDefault     = 16;
	localparam int UidBits             = 128;
	localparam int NodeW               = 7;
	localparam int LenW                = 5;
	localparam logic [15:0] TimeoutReset = 16'd3000;
	localparam logic [6:0]  HighestId    = 7'd125;
	localparam logic [6:0]  LowestId     = 7'd1;
	localparam logic [4:0]  UidLen       = 5'd16;

	localparam logic [2:0] RegOwn     = 3'd0;
	localparam logic [2:0] RegGnss    = 3'd1;
	localparam logic [2:0] RegBattery = 3'd2;
	localparam logic [2:0] RegCompass = 3'd3;
	localparam logic [2:0] RegBase    = 3'd4;
	localparam logic [2:0] RegRover   = 3'd5;
	localparam logic [2:0] RegTimeout = 3'd6;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_FRAG,
		ST_LOOKUP,
		ST_LOOKRD,
		ST_SEARCH,
		ST_SEARCHRD,
		ST_WRITE,
		ST_OUT
	} cdna_state_t;

	// controller -> datapath
	typedef struct packed {
		logic take_item;    // latch input beat
		logic frag_apply;   // evaluate fragment and update pending
		logic scan_clear;   // reset scan index
		logic scan_step;    // advance scan index
		logic cand_init;    // init candidate search
		logic cand_step;    // advance candidate
		logic table_write;  // write new entry
		logic load_hit;     // load output from table hit
		logic out_load;     // output register gets result
		logic out_take;     // output beat taken
	} cdna_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_obs;
		logic frag_emit;    // partial result ready
		logic frag_full;    // complete ID
		logic scan_last;
		logic scan_hit;
		logic cand_free;
		logic cand_done;    // search exhausted
		logic slot_found;
		logic out_busy;
	} cdna_sts_t;

endpackage

@@ sv/can_dynamic_node_id_allocator.sv @@
// Top level of the dynamic node-ID allocator.
//  channel | dir | handshake          | payload
//  in      | in  | in_valid/in_ready  | kind .. observed_node
//  out     | out | out_valid/out_ready| assigned_node .. entry_count
//  cfg     | in  | cfg_we             | cfg_idx, cfg_data
// One item at a time. A fragment is evaluated in ST_FRAG; a complete ID then
// scans the table entries for a lookup, searches the candidate IDs (up to 125),
// and passes through ST_SEARCHRD and ST_WRITE to write the new entry.
// Reset clears table used bits, seen map and pending buffer at once.
// A result beat waiting on out_ready holds off the next input beat.
`timescale 1ns / 1ps
module can_dynamic_node_id_allocator
	import cdna_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntriesDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        kind,
	input  logic [6:0]  source_node,
	input  logic        frame_ok,
	input  logic        first_part,
	input  logic [6:0]  preferred_node,
	input  logic [4:0]  frag_len,
	input  logic [63:0] frag_bytes_low,
	input  logic [63:0] frag_bytes_high,
	input  logic [31:0] now_ms,
	input  logic [6:0]  observed_node,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [6:0]  assigned_node,
	output logic [4:0]  echo_len,
	output logic [63:0] echo_bytes_low,
	output logic [63:0] echo_bytes_high,
	output logic [4:0]  entry_count,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [15:0] cfg_data
);
	cdna_cmd_t cmd;
	cdna_sts_t sts;

	cdna_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
	);

	cdna_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
		.clk, .arst_n, .cmd, .sts, .cfg_we, .cfg_idx, .cfg_data,
		.kind, .source_node, .frame_ok, .first_part, .preferred_node, .frag_len,
		.frag_bytes_low, .frag_bytes_high, .now_ms, .observed_node,
		.assigned_node, .echo_len, .echo_bytes_low, .echo_bytes_high, .entry_count
	);
endmodule

@@ sv/cdna_datapath.sv @@
// Datapath: pending buffer, allocation table, seen map and ID search.
`timescale 1ns / 1ps
module cdna_datapath
	import cdna_pkg::*;
#(
	parameter int TABLE_ENTRIES = TableEntriesDefault
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cdna_cmd_t          cmd,
	output cdna_sts_t          sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic               kind,
	input  logic [6:0]         source_node,
	input  logic               frame_ok,
	input  logic               first_part,
	input  logic [6:0]         preferred_node,
	input  logic [4:0]         frag_len,
	input  logic [63:0]        frag_bytes_low,
	input  logic [63:0]        frag_bytes_high,
	input  logic [31:0]        now_ms,
	input  logic [6:0]         observed_node,
	output logic [6:0]         assigned_node,
	output logic [4:0]         echo_len,
	output logic [63:0]        echo_bytes_low,
	output logic [63:0]        echo_bytes_high,
	output logic [4:0]         entry_count
);
	localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CntW = $clog2(TABLE_ENTRIES + 1);

	logic [6:0]  cfg_id_q [6];
	logic [15:0] timeout_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) cfg_id_q[i] <= '0;
			timeout_q <= TimeoutReset;
		end else if (cfg_we) begin
			case (cfg_idx)
				RegOwn, RegGnss, RegBattery, RegCompass, RegBase, RegRover:
					cfg_id_q[cfg_idx] <= cfg_data[6:0];
				RegTimeout: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched input beat
	logic        kind_q, ok_q, first_q;
	logic [6:0]  src_q, pref_in_q, obs_q;
	logic [4:0]  len_q;
	logic [127:0] frag_q;
	logic [31:0] now_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			kind_q    <= kind;
			src_q     <= source_node;
			ok_q      <= frame_ok;
			first_q   <= first_part;
			pref_in_q <= preferred_node;
			len_q     <= frag_len;
			frag_q    <= {frag_bytes_high, frag_bytes_low};
			now_q     <= now_ms;
			obs_q     <= observed_node;
		end
	end

	// bus seen map (128 flops, cleared at reset)
	logic [127:0] seen_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) seen_q <= '0;
		else if (cmd.frag_apply && kind_q) seen_q[obs_q] <= 1'b1;
	end

	// pending state
	logic [127:0] puid_q;
	logic [4:0]   pcnt_q;
	logic [6:0]   ppref_q;
	logic [31:0]  pstamp_q;

	logic [31:0] age;
	logic        valid_frag, timed_out, go, overflow;
	logic [4:0]  base_cnt;
	logic [5:0]  sum;
	logic [127:0] uid_base, uid_new, frag_mask, frag_sh;
	logic [7:0]  shamt;

	always_comb begin
		age        = now_q - pstamp_q;
		valid_frag = !kind_q && src_q == '0 && ok_q && len_q != '0 && len_q <= UidLen;
		timed_out  = pstamp_q != '0 && age > {16'd0, timeout_q};
		base_cnt   = (first_q || timed_out) ? 5'd0 : pcnt_q;
		go         = valid_frag && (first_q || base_cnt != '0);
		sum        = {1'b0, base_cnt} + {1'b0, len_q};
		overflow   = sum > {1'b0, UidLen};
		uid_base   = first_q ? '0 : puid_q;
		frag_mask  = (len_q[4]) ? '1 : ((128'd1 << {len_q[3:0], 3'b000}) - 128'd1);
		shamt      = {base_cnt[3:0], 3'b000};
		frag_sh    = (frag_q & frag_mask) << shamt;
		uid_new    = (uid_base & ~(frag_mask << shamt)) | frag_sh;
	end

	assign sts.is_obs    = kind_q;
	assign sts.frag_emit = go && !overflow && sum < {1'b0, UidLen};
	assign sts.frag_full = go && !overflow && sum == {1'b0, UidLen};

	// count drops to zero on timeout, overflow and a complete ID; a first part restarts it from its own length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			puid_q   <= '0;
			pcnt_q   <= '0;
			ppref_q  <= '0;
			pstamp_q <= '0;
		end else if (cmd.frag_apply && valid_frag) begin
			if (first_q) ppref_q <= pref_in_q;
			if (go && !overflow) begin
				puid_q   <= uid_new;
				pstamp_q <= now_q;
			end else if (first_q) begin
				puid_q <= '0;
			end
			if (go && !overflow && !sum[4]) pcnt_q <= sum[4:0];
			else pcnt_q <= '0;
		end
	end

	// allocation table: used bits in flops, uid/node in memory
	logic [TABLE_ENTRIES-1:0] used_q;
	logic [127:0] tuid_mem [TABLE_ENTRIES];
	logic [6:0]   tnode_mem [TABLE_ENTRIES];
	logic [IdxW:0] scan_q;
	logic [127:0] rd_uid_q;
	logic [6:0]   rd_node_q;
	logic         rd_used_q;
	logic [IdxW-1:0] slot_q;
	logic         slot_ok_q;
	logic [6:0]   cand_q;

	always_ff @(posedge clk) begin
		rd_uid_q  <= tuid_mem[scan_q[IdxW-1:0]];
		rd_node_q <= tnode_mem[scan_q[IdxW-1:0]];
		if (cmd.table_write) begin
			tuid_mem[slot_q]  <= puid_q;
			tnode_mem[slot_q] <= cand_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			scan_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			rd_used_q <= used_q[scan_q[IdxW-1:0]];
			if (cmd.scan_clear) scan_q <= '0;
			else if (cmd.scan_step) scan_q <= scan_q + 1'b1;
			if (cmd.table_write) used_q[slot_q] <= 1'b1;
		end
	end

	// lookup of the registered read corresponds to scan_q (held during compare)
	assign sts.scan_hit  = rd_used_q && rd_uid_q == puid_q;
	assign sts.scan_last = scan_q == (IdxW+1)'(TABLE_ENTRIES - 1);

	// first free slot via priority over flops
	logic [IdxW-1:0] slot_d;
	logic            slot_ok_d;
	always_comb begin
		slot_d    = '0;
		slot_ok_d = 1'b0;
		for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
			if (!used_q[i]) begin
				slot_d    = IdxW'(i);
				slot_ok_d = 1'b1;
			end
	end

	always_ff @(posedge clk) begin
		if (cmd.cand_init) begin
			slot_q    <= slot_d;
			slot_ok_q <= slot_ok_d;
		end
	end
	assign sts.slot_found = slot_ok_q;

	// mirror of table node IDs in flops for the parallel compare
	logic [6:0] tnode_dup_q [TABLE_ENTRIES];
	always_ff @(posedge clk) begin
		if (cmd.table_write) tnode_dup_q[slot_q] <= cand_q;
	end

	// candidate search: one ID per cycle, checks against config, table and seen
	logic down_q, done_q;
	logic [6:0] pref_lat_q;
	logic cand_hit_tab;
	logic cand_cfg;
	always_comb begin
		cand_hit_tab = 1'b0;
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (used_q[i] && tnode_dup_q[i] == cand_q) cand_hit_tab = 1'b1;
		cand_cfg = 1'b0;
		for (int i = 0; i < 6; i++)
			if (cfg_id_q[i] == cand_q) cand_cfg = 1'b1;
	end

	assign sts.cand_free = !done_q && cand_q >= LowestId && cand_q <= HighestId
		&& !cand_cfg && !cand_hit_tab && !seen_q[cand_q];
	assign sts.cand_done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0; down_q <= 1'b0; done_q <= 1'b0;
			pref_lat_q <= '0;
		end else if (cmd.cand_init) begin
			done_q     <= 1'b0;
			pref_lat_q <= ppref_q;
			if (ppref_q >= LowestId && ppref_q <= HighestId) begin
				down_q <= 1'b0; cand_q <= ppref_q;
			end else begin
				down_q <= 1'b1; cand_q <= HighestId;
			end
		end else if (cmd.cand_step) begin
			if (!down_q) begin
				if (cand_q == HighestId) begin
					down_q <= 1'b1;
					if (pref_lat_q == LowestId) done_q <= 1'b1;
					cand_q <= pref_lat_q - 7'd1;
				end else cand_q <= cand_q + 7'd1;
			end else begin
				if (cand_q <= LowestId) done_q <= 1'b1;
				else cand_q <= cand_q - 7'd1;
			end
		end
	end

	// output register
	logic [CntW-1:0] used_cnt;
	always_comb begin
		used_cnt = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) used_cnt = used_cnt + CntW'(used_q[i]);
	end

	logic out_busy_q;
	logic [127:0] emask;
	assign emask = (sum[4]) ? '1 : ((128'd1 << {sum[3:0], 3'b000}) - 128'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_busy_q <= 1'b0;
		else if (cmd.out_load || cmd.load_hit) out_busy_q <= 1'b1;
		else if (cmd.out_take) out_busy_q <= 1'b0;
	end
	assign sts.out_busy = out_busy_q;

	logic [127:0] echo_q;
	always_ff @(posedge clk) begin
		if (cmd.frag_apply) begin
			echo_q        <= uid_new & emask;
			echo_len      <= sum[4:0];
			assigned_node <= '0;
		end else if (cmd.load_hit) begin
			assigned_node <= rd_node_q;
			echo_q        <= puid_q;
			echo_len      <= UidLen;
		end else if (cmd.table_write) begin
			assigned_node <= cand_q;
			echo_q        <= puid_q;
			echo_len      <= UidLen;
		end
		// a new entry counts in the beat that reports it
		if (cmd.table_write) entry_count <= 5'(used_cnt) + 5'd1;
		else if (cmd.out_load || cmd.load_hit) entry_count <= 5'(used_cnt);
	end
	assign echo_bytes_low  = echo_q[63:0];
	assign echo_bytes_high = echo_q[127:64];
endmodule

@@ sv/cdna_ctrl.sv @@
// Controller state machine sequencing fragment, lookup, search and output.
`timescale 1ns / 1ps
module cdna_ctrl
	import cdna_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output cdna_cmd_t cmd,
	input  cdna_sts_t sts
);
	cdna_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign in_ready  = state_q == ST_IDLE && !sts.out_busy;
	assign out_valid = sts.out_busy;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid && in_ready) state_d = ST_FRAG;
			ST_FRAG: begin
				if (sts.frag_full) state_d = ST_LOOKRD;
				else state_d = ST_IDLE;
			end
			ST_LOOKRD:   state_d = ST_LOOKUP;
			ST_LOOKUP: begin
				if (sts.scan_hit) state_d = ST_IDLE;
				else if (sts.scan_last) state_d = ST_SEARCH;
				else state_d = ST_LOOKRD;
			end
			ST_SEARCH: begin
				if (sts.cand_done) state_d = ST_IDLE;
				else if (sts.cand_free) state_d = ST_SEARCHRD;
			end
			ST_SEARCHRD: state_d = sts.slot_found ? ST_WRITE : ST_IDLE;
			ST_WRITE:    state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.out_take = out_valid && out_ready;
		case (state_q)
			ST_IDLE:   cmd.take_item = in_valid && in_ready;
			ST_FRAG: begin
				cmd.frag_apply = 1'b1;
				cmd.scan_clear = 1'b1;
				cmd.out_load   = sts.frag_emit;
			end
			ST_LOOKUP: begin
				cmd.load_hit  = sts.scan_hit;
				cmd.scan_step = !sts.scan_hit && !sts.scan_last;
				cmd.cand_init = !sts.scan_hit && sts.scan_last;
			end
			ST_SEARCH:   cmd.cand_step = !sts.cand_done && !sts.cand_free;
			ST_WRITE: begin
				cmd.table_write = 1'b1;
				cmd.out_load    = 1'b1;
			end
			default: ;
		endcase
	end
endmodule
